// ===== rtl/core/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

   localparam int unsigned DEPTH_DEFAULT      = 1024;
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   localparam int unsigned MODE_W   = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned POS_W    = 10;
   localparam int unsigned FILL_W   = 11;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_BACK   = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_PEEK_BACK  = 3'd4,
      MODE_PEEK_FRONT = 3'd5,
      MODE_READ_AT    = 3'd6,
      MODE_CLEAR      = 3'd7
   } deq_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } deq_status_type;

   // per-command result info from the pointer logic to the output register
   typedef struct packed {
      logic [FILL_W-1:0] fill_count;
      deq_status_type    status;
      logic              has_element;
   } deq_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/deq_ram.sv =====
`default_nettype none

module deq_ram #(
   parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]    rd_data
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
`default_nettype none

module deq_ctrl #(
   parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [deq_pkg::MODE_W-1:0]    mode,
   input  wire logic [deq_pkg::VALUE_W-1:0]   push_value,
   input  wire logic [deq_pkg::POS_W-1:0]     position,
   output logic                               wr_en,
   output logic      [$clog2(DEPTH)-1:0]      wr_addr,
   output logic      [DATA_WIDTH-1:0]         wr_data,
   output logic      [$clog2(DEPTH)-1:0]      rd_addr,
   output deq_pkg::deq_result_type            result
);
   import deq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned OW = (CW > POS_W) ? CW : POS_W;

   logic [AW-1:0] head_ff;
   logic [AW-1:0] head_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic          empty;
   logic          full;
   logic [AW-1:0] head_inc;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] tail_addr;
   logic [AW-1:0] back_addr;
   logic [AW-1:0] pos_addr;
   logic [OW-1:0] pos_ext;
   logic [OW-1:0] count_ext;
   logic [CW-1:0] count_less;
   deq_mode_type  mode_sel;
   deq_status_type status;
   logic          has_element;

   // head plus an offset below DEPTH, folded back into the ring
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] offset);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CW'(DEPTH));
   assign count_less = count_ff - CW'(1);
   assign head_inc   = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign head_dec   = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign tail_addr  = ring_add(head_ff, count_ff[AW-1:0]);
   assign back_addr  = ring_add(head_ff, count_less[AW-1:0]);
   assign pos_ext    = OW'(position);
   assign count_ext  = OW'(count_ff);
   assign pos_addr   = ring_add(head_ff, pos_ext[AW-1:0]);
   assign mode_sel   = deq_mode_type'(mode);
   assign wr_data    = DATA_WIDTH'(push_value);

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = tail_addr;
      rd_addr     = head_ff;
      status      = STATUS_OK;
      has_element = 1'b0;
      unique case (mode_sel) inside
         MODE_PUSH_BACK: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_PUSH_FRONT: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               wr_en    = accept;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_POP_BACK, MODE_PEEK_BACK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               rd_addr     = back_addr;
               has_element = 1'b1;
               if (mode_sel == MODE_POP_BACK) begin
                  count_in = count_less;
               end
            end
         end
         MODE_POP_FRONT, MODE_PEEK_FRONT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               has_element = 1'b1;
               if (mode_sel == MODE_POP_FRONT) begin
                  head_in  = head_inc;
                  count_in = count_less;
               end
            end
         end
         MODE_READ_AT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else if (pos_ext >= count_ext) begin
               status = STATUS_RANGE;
            end else begin
               rd_addr     = pos_addr;
               has_element = 1'b1;
            end
         end
         MODE_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
      endcase
   end

   assign result.fill_count  = FILL_W'(count_in);
   assign result.status      = status;
   assign result.has_element = has_element;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Double-ended queue of DEPTH entries of DATA_WIDTH bits in a ring held in one
// synchronous RAM, with the head pointer and fill count in registers. Each
// request is one command (push or pop at either end, peek at either end, read
// at an offset from the front, or clear) and gives exactly one response with
// the element (zero when none), the fill count after the command and a status.
// A command is accepted, its RAM accesses are issued in that cycle, and its
// response is valid in the output register on the next cycle, so one command per
// cycle is sustained while rsp_stall stays low. The RAM needs one write and one
// read port; a push writes and every command reads, and a read in the cycle after
// a write already sees the written data. The store is not cleared after reset;
// entries are only read after they were written.
`default_nettype none

module double_ended_queue #(
   parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [deq_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [deq_pkg::VALUE_W-1:0]    req_push_value,
   input  wire logic [deq_pkg::POS_W-1:0]      req_position,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [deq_pkg::VALUE_W-1:0]    rsp_element,
   output logic      [deq_pkg::FILL_W-1:0]     rsp_fill_count,
   output logic      [deq_pkg::STATUS_W-1:0]   rsp_status
);
   import deq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic                  accept;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   deq_result_type        result_in;
   deq_result_type        result_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   // a new command is taken whenever the output register is free or drains,
   // never during reset
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_mode),
      .push_value (req_push_value),
      .position   (req_position),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .result     (result_in)
   );

   deq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_element    = result_ff.has_element ? VALUE_W'(rd_data) : '0;
   assign rsp_fill_count = result_ff.fill_count;
   assign rsp_status     = result_ff.status;

endmodule

`default_nettype wire

// ===== dv/double_ended_queue_tb.sv =====
`default_nettype none

module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int unsigned RANDOM_PER_PHASE = 132;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 4;

   typedef struct {
      logic [VALUE_W-1:0] element;
      logic [FILL_W-1:0]  fill_count;
      deq_status_type     status;
   } queue_response_type;

   // mirrors the queue contents and holds the responses still owed by the dut
   class deque_shadow_type;
      logic [VALUE_W-1:0] stored[$];
      queue_response_type due[$];
      int                 mismatches;

      function void note_command(deq_mode_type mode, logic [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         queue_response_type r;
         r.element = '0;
         r.status = STATUS_OK;
         case (mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
               if (stored.size() >= QUEUE_DEPTH)
                  r.status = STATUS_FULL;
               else if (mode == MODE_PUSH_BACK)
                  stored.insert(stored.size(), value);
               else
                  stored.insert(0, value);
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
               if (stored.size() == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.element = stored[$];
                  if (mode == MODE_POP_BACK)
                     stored.delete(stored.size() - 1);
               end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
               if (stored.size() == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.element = stored[0];
                  if (mode == MODE_POP_FRONT)
                     stored.delete(0);
               end
            end
            MODE_READ_AT: begin
               // empty wins over the range check
               if (stored.size() == 0)
                  r.status = STATUS_EMPTY;
               else if (int'(pos) >= stored.size())
                  r.status = STATUS_RANGE;
               else
                  r.element = stored[pos];
            end
            default: begin
               stored.delete();
            end
         endcase
         r.fill_count = FILL_W'(stored.size());
         due.insert(due.size(), r);
      endfunction

      function void check_response(logic [VALUE_W-1:0] element,
                                   logic [FILL_W-1:0] fill_count,
                                   logic [STATUS_W-1:0] status);
         queue_response_type r;
         if (due.size() == 0) begin
            $error("response with nothing outstanding: element %h fill %0d status %0d",
                   element, fill_count, status);
            mismatches++;
            return;
         end
         r = due[0];
         due.delete(0);
         if (element !== r.element) begin
            $error("rsp_element: expected %h, got %h", r.element, element);
            mismatches++;
         end
         if (fill_count !== r.fill_count) begin
            $error("rsp_fill_count: expected %0d, got %0d", r.fill_count, fill_count);
            mismatches++;
         end
         if (status !== r.status) begin
            $error("rsp_status: expected %0d, got %0d", r.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [VALUE_W-1:0]  req_push_value = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_element;
   logic [FILL_W-1:0]   rsp_fill_count;
   logic [STATUS_W-1:0] rsp_status;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned cycle_count = 0;

   deque_shadow_type shadow = new();

   double_ended_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_element    (rsp_element),
      .rsp_fill_count (rsp_fill_count),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("double_ended_queue_tb: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_response(rsp_element, rsp_fill_count, rsp_status);
   end

   // presents one command and returns at the edge where the transfer happens
   task automatic send_command(input deq_mode_type mode, input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_push_value <= value;
      req_position <= pos;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      shadow.note_command(mode, value, pos);
   endtask

   task automatic random_command();
      int unsigned        fill;
      int unsigned        pick;
      deq_mode_type       mode;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      fill = shadow.stored.size();
      pick = $urandom_range(0, 99);
      if (pick < 22)
         mode = MODE_PUSH_BACK;
      else if (pick < 40)
         mode = MODE_PUSH_FRONT;
      else if (pick < 52)
         mode = MODE_POP_BACK;
      else if (pick < 64)
         mode = MODE_POP_FRONT;
      else if (pick < 71)
         mode = MODE_PEEK_BACK;
      else if (pick < 78)
         mode = MODE_PEEK_FRONT;
      else if (pick < 98)
         mode = MODE_READ_AT;
      else
         mode = MODE_CLEAR;
      value = $urandom();
      case ($urandom_range(0, 9))
         0: value = '0;
         1: value = '1;
         default: ;
      endcase
      pos = POS_W'($urandom_range(0, QUEUE_DEPTH - 1));
      // mostly in range, sometimes right at the fill boundary
      if (fill > 0 && $urandom_range(0, 3) != 0)
         pos = POS_W'($urandom_range(0, fill - 1));
      else if (fill < QUEUE_DEPTH && $urandom_range(0, 1) == 0)
         pos = POS_W'(fill);
      send_command(mode, value, pos);
   endtask

   initial begin
      int unsigned idle_plan[4];
      int unsigned stall_plan[4];
      idle_plan = '{0, 46, 0, 26};
      stall_plan = '{0, 0, 46, 26};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue on every read path
      send_command(MODE_PEEK_BACK, '0, '0);
      send_command(MODE_PEEK_FRONT, '0, '0);
      send_command(MODE_POP_BACK, '0, '0);
      send_command(MODE_POP_FRONT, '0, '0);
      send_command(MODE_READ_AT, '1, '1);
      send_command(MODE_PUSH_BACK, '0, '0);
      // front push from head zero wraps the ring
      send_command(MODE_PUSH_FRONT, '1, '0);
      send_command(MODE_PUSH_BACK, 32'h8000_0001, '0);
      send_command(MODE_READ_AT, '0, 10'd0);
      send_command(MODE_READ_AT, '0, 10'd2);
      send_command(MODE_READ_AT, '0, 10'd3);
      send_command(MODE_READ_AT, '0, '1);
      send_command(MODE_PEEK_BACK, '0, '0);
      send_command(MODE_PEEK_FRONT, '0, '0);
      send_command(MODE_POP_FRONT, '0, '0);
      send_command(MODE_POP_BACK, '0, '0);
      send_command(MODE_CLEAR, '0, '0);
      send_command(MODE_READ_AT, '0, '0);
      send_command(MODE_POP_FRONT, '0, '0);
      send_command(MODE_PUSH_FRONT, 32'h5A5A_A5A5, '0);
      send_command(MODE_POP_BACK, '0, '0);
      send_command(MODE_PUSH_BACK, 32'h0000_0001, '0);
      send_command(MODE_CLEAR, '0, '0);

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_plan[phase];
         receiver_stall_pct = stall_plan[phase];
         repeat (RANDOM_PER_PHASE)
            random_command();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.mismatches == 0)
         $display("double_ended_queue_tb: done, clean");
      else
         $display("double_ended_queue_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== double_ended_queue.f =====
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue.sv
dv/double_ended_queue_tb.sv
